/* design/i2cms_pkg.sv */
// Shared types, codes and defaults for the I2C master transfer sequencer.
`default_nettype none

package i2cms_pkg;

  // Default message buffer depth in bytes.
  localparam int unsigned BUF_DEPTH_DEF = 16;

  // Operation codes carried in the input word.
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_EVENT = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  // Bus status events reported by the byte engine.
  typedef enum logic [2:0] {
    EV_START    = 3'd0,
    EV_RSTART   = 3'd1,
    EV_ADDRW_ACK = 3'd2,
    EV_DATAW_ACK = 3'd3,
    EV_ADDRR_ACK = 3'd4,
    EV_RX_ACK   = 3'd5,
    EV_RX_NACK  = 3'd6,
    EV_ERROR    = 3'd7
  } ev_e;

  // Actions requested from the byte engine.
  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_NACK  = 3'd2,
    ACT_ACK   = 3'd3,
    ACT_STOP  = 3'd4,
    ACT_ABORT = 3'd5
  } act_e;

  // Input word.
  typedef struct packed {
    logic [1:0] op;
    logic [3:0] index;
    logic [7:0] byte_value;
    logic [4:0] msg_size;
    logic [2:0] bus_event;
  } in_t;

  // Output word.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_load;
    logic [2:0] action;
    logic       busy_res;
    logic       transfer_ok;
    logic [7:0] read_data;
    logic       read_valid;
  } out_t;

  // Result fields known at accept time; the buffer byte follows from memory.
  typedef struct packed {
    logic       tx_load;
    act_e       action;
    logic       busy;
    logic       ok;
    logic       read_valid;
  } meta_t;

endpackage

`default_nettype wire

/* design/i2cms_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module i2cms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* design/i2cms_ctrl.sv */
// Transfer control state and buffer addressing for each accepted word.
`default_nettype none

module i2cms_ctrl #(
  parameter int unsigned BUF_DEPTH = i2cms_pkg::BUF_DEPTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         accept_i,
  input  wire i2cms_pkg::in_t               in_i,
  output logic                              we_o,
  output logic [$clog2(BUF_DEPTH)-1:0]      waddr_o,
  output logic [7:0]                        wdata_o,
  output logic                              re_o,
  output logic [$clog2(BUF_DEPTH)-1:0]      raddr_o,
  output i2cms_pkg::meta_t                  meta_o
);

  localparam int unsigned AW   = $clog2(BUF_DEPTH);
  localparam int unsigned PW   = $clog2(BUF_DEPTH + 1);
  localparam int unsigned CMPW = (PW > 5) ? PW : 5;
  localparam logic [PW-1:0]   DEPTH_P = PW'(BUF_DEPTH);
  localparam logic [CMPW-1:0] DEPTH_C = CMPW'(BUF_DEPTH);

  logic [PW-1:0]   ptr_q, ptr_d, ptr_base;
  logic [PW-1:0]   size_q, size_d;
  logic            busy_q, busy_d;
  logic            ok_q, ok_d;
  logic [CMPW-1:0] idx_ext, msz_ext;
  logic            idx_in_range;
  logic            we;
  logic            re;

  assign idx_ext      = CMPW'(in_i.index);
  assign msz_ext      = CMPW'(in_i.msg_size);
  assign idx_in_range = idx_ext < DEPTH_C;
  assign wdata_o      = in_i.byte_value;

  // Next state, memory requests and result fields for the offered word.
  always_comb begin
    ptr_d    = ptr_q;
    size_d   = size_q;
    busy_d   = busy_q;
    ok_d     = ok_q;
    ptr_base = ptr_q;
    we       = 1'b0;
    re       = 1'b0;
    waddr_o  = AW'(idx_ext);
    raddr_o  = AW'(idx_ext);
    meta_o   = '0;
    meta_o.action = i2cms_pkg::ACT_NONE;
    unique case (in_i.op)
      i2cms_pkg::OP_LOAD: begin
        we = !busy_q && idx_in_range;
      end
      i2cms_pkg::OP_START: begin
        size_d = (msz_ext > DEPTH_C) ? DEPTH_P : PW'(msz_ext);
        ok_d   = 1'b0;
        busy_d = 1'b1;
        meta_o.action = i2cms_pkg::ACT_START;
      end
      i2cms_pkg::OP_EVENT: begin
        if (busy_q) begin
          priority if (in_i.bus_event == i2cms_pkg::EV_START ||
                       in_i.bus_event == i2cms_pkg::EV_RSTART ||
                       in_i.bus_event == i2cms_pkg::EV_ADDRW_ACK ||
                       in_i.bus_event == i2cms_pkg::EV_DATAW_ACK) begin
            // Transmit path: send the next byte or finish with a stop.
            if (in_i.bus_event == i2cms_pkg::EV_START ||
                in_i.bus_event == i2cms_pkg::EV_RSTART) begin
              ptr_base = '0;
            end
            if (ptr_base < size_q) begin
              re      = 1'b1;
              raddr_o = AW'(ptr_base);
              ptr_d   = ptr_base + PW'(1);
              meta_o.tx_load = 1'b1;
              meta_o.action  = i2cms_pkg::ACT_NACK;
            end else begin
              ptr_d  = ptr_base;
              ok_d   = 1'b1;
              busy_d = 1'b0;
              meta_o.action = i2cms_pkg::ACT_STOP;
            end
          end else if (in_i.bus_event == i2cms_pkg::EV_ADDRR_ACK ||
                       in_i.bus_event == i2cms_pkg::EV_RX_ACK) begin
            // Receive path: store a received data byte and pick ACK or NACK for the next.
            if (in_i.bus_event == i2cms_pkg::EV_RX_ACK && ptr_q < DEPTH_P) begin
              we      = 1'b1;
              waddr_o = AW'(ptr_q);
              ptr_d   = ptr_q + PW'(1);
            end
            meta_o.action = (({1'b0, ptr_d} + (PW + 1)'(1)) < {1'b0, size_q}) ?
                            i2cms_pkg::ACT_ACK : i2cms_pkg::ACT_NACK;
          end else if (in_i.bus_event == i2cms_pkg::EV_RX_NACK) begin
            // Last byte received: store it and stop.
            if (ptr_q < DEPTH_P) begin
              we      = 1'b1;
              waddr_o = AW'(ptr_q);
            end
            ok_d   = 1'b1;
            busy_d = 1'b0;
            meta_o.action = i2cms_pkg::ACT_STOP;
          end else begin
            ok_d   = 1'b0;
            busy_d = 1'b0;
            meta_o.action = i2cms_pkg::ACT_ABORT;
          end
        end
      end
      i2cms_pkg::OP_READ: begin
        if (!busy_q && ok_q && idx_in_range) begin
          re = 1'b1;
          meta_o.read_valid = 1'b1;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
    meta_o.busy = busy_d;
    meta_o.ok   = ok_d;
  end

  assign we_o = accept_i && we;
  assign re_o = accept_i && re;

  // Control registers advance only on an accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      size_q <= '0;
      busy_q <= 1'b0;
      ok_q   <= 1'b0;
    end else if (accept_i) begin
      ptr_q  <= ptr_d;
      size_q <= size_d;
      busy_q <= busy_d;
      ok_q   <= ok_d;
    end
  end

endmodule

`default_nettype wire

/* design/i2c_master_transfer_sequencer_top.sv */
// Top level of the I2C master transfer sequencer: control, buffer and output stage.
//
// Usage: each input word on in_data_i carries one operation (load a buffer
// byte, start a transfer, report a bus event with its received byte, or read
// a buffer byte). Every accepted word gives exactly one output word on
// out_data_o with the next engine action, the byte to transmit, the busy and
// success flags, and read data where the read is valid.
// Both channels use valid/ready; a word moves when both are high.
// A result passes through the middle stage, where the registered buffer read
// lands, and then through the output register.
// Throughput: one word per cycle while the output is not stalled; control state updates at accept and the
// buffer is written in the same cycle, so the next word reads current data.
// Reset clears the pointer, size, busy and success flags and empties the
// pipeline. The buffer contents are undefined until written.
// When the receiver stalls, the output word holds and one more word is taken
// into the middle stage; then in_ready_o drops until the output drains.
`default_nettype none

module i2c_master_transfer_sequencer_top #(
  parameter int unsigned BUF_DEPTH = i2cms_pkg::BUF_DEPTH_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire i2cms_pkg::in_t  in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output i2cms_pkg::out_t      out_data_o
);

  localparam int unsigned AW = $clog2(BUF_DEPTH);

  logic                    accept;
  logic                    advance;
  logic                    we, re;
  logic [AW-1:0]           waddr, raddr;
  logic [7:0]              wdata, rdata;
  i2cms_pkg::meta_t        meta;
  logic                    s1_valid_q;
  i2cms_pkg::meta_t        s1_meta_q;
  logic                    out_valid_q;
  i2cms_pkg::out_t         out_data_q;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  i2cms_ctrl #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_data_i),
    .we_o     (we),
    .waddr_o  (waddr),
    .wdata_o  (wdata),
    .re_o     (re),
    .raddr_o  (raddr),
    .meta_o   (meta)
  );

  i2cms_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Middle stage: result fields wait here alongside the buffer read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_meta_q <= meta;
    end
  end

  // Output register: combines the result fields with the buffer byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_data_q.tx_byte     <= s1_meta_q.tx_load ? rdata : 8'd0;
      out_data_q.tx_load     <= s1_meta_q.tx_load;
      out_data_q.action      <= s1_meta_q.action;
      out_data_q.busy_res    <= s1_meta_q.busy;
      out_data_q.transfer_ok <= s1_meta_q.ok;
      out_data_q.read_data   <= s1_meta_q.read_valid ? rdata : 8'd0;
      out_data_q.read_valid  <= s1_meta_q.read_valid;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

/* design/i2cms_checker.sv */
// Port-level checker for the I2C master transfer sequencer, with its bind.
`default_nettype none

module i2cms_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            out_valid_o,
  input wire logic            out_ready_i,
  input wire i2cms_pkg::out_t out_data_o
);

  // A stalled output word keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // A valid read only happens while idle after a successful transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.read_valid |->
      !out_data_o.busy_res && out_data_o.transfer_ok)
    else $error("read reported valid outside an idle successful state");

  // A byte to transmit always comes with continue-NACK, and never with a read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.tx_load |->
      out_data_o.action == i2cms_pkg::ACT_NACK && !out_data_o.read_valid)
    else $error("tx_load without continue action");

  // A start request leaves the block busy and not yet successful.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.action == i2cms_pkg::ACT_START |->
      out_data_o.busy_res && !out_data_o.transfer_ok)
    else $error("start result with wrong flags");

  // Stop and abort always end the transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.action == i2cms_pkg::ACT_STOP ||
                    out_data_o.action == i2cms_pkg::ACT_ABORT) |->
      !out_data_o.busy_res)
    else $error("transfer still busy after stop or abort");

endmodule

bind i2c_master_transfer_sequencer_top i2cms_checker u_i2cms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

/* tb/i2cms_reply_checker.sv */
// Checker for the I2C master transfer sequencer: predicts every reply word and compares it.
module i2cms_reply_checker #(
  parameter int DEPTH = i2cms_pkg::BUF_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  i2cms_pkg::in_t  in_data_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  i2cms_pkg::out_t out_data_i,
  output int              errors_o,
  output int              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import i2cms_pkg::*;

  // Private copy of the sequencer state.
  logic [7:0] msg_mem [DEPTH];
  int         next_pos;
  int         xfer_len;
  logic       busy_now;
  logic       ok_now;

  // Reply words predicted but not yet seen, oldest first.
  out_t       replies [$];
  int         mismatches = 0;

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what);
    $display("%0t ns: sequencer reply mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
    end
  endtask

  // Applies one accepted word to the state and works out the engine reply.
  task automatic advance_sequencer(input in_t w, output out_t r);
    r = '0;
    case (w.op)
      OP_LOAD: begin
        if (!busy_now && w.index < DEPTH) begin
          msg_mem[w.index] = w.byte_value;
        end
      end
      OP_START: begin
        xfer_len = (w.msg_size > DEPTH) ? DEPTH : int'(w.msg_size);
        ok_now = 1'b0;
        busy_now = 1'b1;
        r.action = ACT_START;
      end
      OP_EVENT: begin
        if (busy_now) begin
          if (w.bus_event <= EV_DATAW_ACK) begin
            // Start conditions rewind to the address byte.
            if (w.bus_event <= EV_RSTART) begin
              next_pos = 0;
            end
            if (next_pos < xfer_len && next_pos < DEPTH) begin
              r.tx_byte = msg_mem[next_pos];
              r.tx_load = 1'b1;
              next_pos++;
              r.action = ACT_NACK;
            end else begin
              ok_now = 1'b1;
              busy_now = 1'b0;
              r.action = ACT_STOP;
            end
          end else if (w.bus_event == EV_ADDRR_ACK || w.bus_event == EV_RX_ACK) begin
            // A received byte past the buffer is dropped; the pointer saturates.
            if (w.bus_event == EV_RX_ACK && next_pos < DEPTH) begin
              msg_mem[next_pos] = w.byte_value;
              next_pos++;
            end
            r.action = (next_pos + 1 < xfer_len) ? ACT_ACK : ACT_NACK;
          end else if (w.bus_event == EV_RX_NACK) begin
            if (next_pos < DEPTH) begin
              msg_mem[next_pos] = w.byte_value;
            end
            ok_now = 1'b1;
            busy_now = 1'b0;
            r.action = ACT_STOP;
          end else begin
            ok_now = 1'b0;
            busy_now = 1'b0;
            r.action = ACT_ABORT;
          end
        end
      end
      default: begin
        if (!busy_now && ok_now && w.index < DEPTH) begin
          r.read_data = msg_mem[w.index];
          r.read_valid = 1'b1;
        end
      end
    endcase
    r.busy_res = busy_now;
    r.transfer_ok = ok_now;
  endtask

  // Watch both channels: predict on input words, compare on output words.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_t want;
    if (!rst_ni) begin
      next_pos = 0;
      xfer_len = 0;
      busy_now = 1'b0;
      ok_now = 1'b0;
      replies.delete();
      pending_o <= 0;
      errors_o <= mismatches;
    end else begin
      if (in_valid_i && in_ready_i) begin
        advance_sequencer(in_data_i, want);
        replies.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        if (replies.size() == 0) begin
          report_mismatch("reply word with no word waiting for it");
        end else begin
          want = replies.pop_front();
          check_field("tx_byte", out_data_i.tx_byte, want.tx_byte);
          check_field("tx_load", 8'(out_data_i.tx_load), 8'(want.tx_load));
          check_field("action", 8'(out_data_i.action), 8'(want.action));
          check_field("busy_res", 8'(out_data_i.busy_res), 8'(want.busy_res));
          check_field("transfer_ok", 8'(out_data_i.transfer_ok),
                      8'(want.transfer_ok));
          check_field("read_data", out_data_i.read_data, want.read_data);
          check_field("read_valid", 8'(out_data_i.read_valid), 8'(want.read_valid));
        end
      end
      pending_o <= replies.size();
      errors_o <= mismatches;
    end
  end

endmodule

/* tb/i2c_master_transfer_sequencer_top_tb.sv */
// Testbench top for the I2C master transfer sequencer: stimulus, flow control and verdict.
module i2c_master_transfer_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cms_pkg::*;

  localparam int DEPTH = BUF_DEPTH_DEF;
  localparam int TARGET_WORDS = 700;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_t  in_data = '0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int   errors;
  int   pending;

  // Sender and receiver pacing state.
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;
  int   stall_mode = 0;
  int   mode_left = 0;
  int   tick = 0;
  int   burst_left = 0;
  int   offered = 0;

  always #4ns clk = ~clk;

  i2c_master_transfer_sequencer_top #(
    .BUF_DEPTH(DEPTH)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  i2cms_reply_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  // Receiver: one long hold-off on request, otherwise a changing stall pattern.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      tick++;
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (tick % 4) != 0;
        default: out_ready <= (tick % 7) < 2;
      endcase
    end
  end

  // Random filler in every field, with the operation forced.
  function automatic in_t word_of(input op_e op);
    logic [31:0] noise;
    noise = $urandom;
    word_of = noise[$bits(in_t)-1:0];
    word_of.op = op;
  endfunction

  // Offers one word in bursts with random gaps, and waits for it to be taken.
  task automatic offer(input in_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    offered++;
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic load_byte(input int idx, input logic [7:0] val);
    in_t w;
    w = word_of(OP_LOAD);
    w.index = 4'(idx);
    w.byte_value = val;
    offer(w);
  endtask

  task automatic start_xfer(input int len);
    in_t w;
    w = word_of(OP_START);
    w.msg_size = 5'(len);
    offer(w);
  endtask

  // The received byte stays random.
  task automatic bus_report(input ev_e ev);
    in_t w;
    w = word_of(OP_EVENT);
    w.bus_event = ev;
    offer(w);
  endtask

  task automatic read_byte(input int idx);
    in_t w;
    w = word_of(OP_READ);
    w.index = 4'(idx);
    offer(w);
  endtask

  // Stops sending until every reply has come back.
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly short messages, with zero, full and oversized lengths mixed in.
  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 0;
    if (r <= 2) return DEPTH;
    if (r == 3) return $urandom_range(DEPTH + 1, 31);
    return $urandom_range(1, 6);
  endfunction

  // Load a message, start, and walk the write path to the stop or an error.
  task automatic write_transfer();
    int len;
    int eff;
    int cut;
    logic [7:0] b;
    ev_e ev;
    len = pick_size();
    eff = (len > DEPTH) ? DEPTH : len;
    for (int i = 0; i < eff; i++) begin
      b = 8'($urandom);
      if (i == 0) b[0] = 1'b0;
      load_byte(i, b);
    end
    start_xfer(len);
    cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, eff) : eff + 1;
    for (int i = 0; i < cut; i++) begin
      if (i == 0) begin
        ev = ($urandom_range(0, 3) == 0) ? EV_RSTART : EV_START;
      end else if (i == 1) begin
        ev = EV_ADDRW_ACK;
      end else begin
        ev = EV_DATAW_ACK;
      end
      bus_report(ev);
    end
    if (cut <= eff) bus_report(EV_ERROR);
    repeat ($urandom_range(0, 3)) read_byte($urandom_range(0, 15));
  endtask

  // Address byte with the read bit, then receive until the final NACK.
  task automatic read_transfer();
    int len;
    int eff;
    int acks;
    logic [7:0] b;
    len = pick_size();
    eff = (len > DEPTH) ? DEPTH : len;
    b = 8'($urandom);
    b[0] = 1'b1;
    load_byte(0, b);
    start_xfer(len);
    bus_report(($urandom_range(0, 3) == 0) ? EV_RSTART : EV_START);
    bus_report(EV_ADDRR_ACK);
    acks = (eff >= 2) ? eff - 2 : 0;
    // Extra bytes push the pointer past the end of the buffer.
    if ($urandom_range(0, 5) == 0 || (len >= DEPTH && $urandom_range(0, 3) != 0)) begin
      acks += $urandom_range(1, 4);
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(0, acks)) bus_report(EV_RX_ACK);
      bus_report(EV_ERROR);
    end else begin
      repeat (acks) bus_report(EV_RX_ACK);
      bus_report(EV_RX_NACK);
    end
    repeat ($urandom_range(1, 4)) read_byte($urandom_range(0, 15));
  endtask

  // Main stimulus.
  initial begin
    int waited;
    logic drained;
    in_t w;
    drained = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole buffer first so that no entry is ever read unwritten.
    for (int i = 0; i < DEPTH; i++) begin
      load_byte(i, (i == 0) ? 8'hA4 : (i == 1) ? 8'h00 : (i == 2) ? 8'hFF : 8'($urandom));
    end
    // No transfer has succeeded yet, and an event while idle does nothing.
    read_byte(0);
    bus_report(EV_RX_ACK);
    // A short write that ends with a stop.
    start_xfer(3);
    bus_report(EV_START);
    bus_report(EV_ADDRW_ACK);
    bus_report(EV_DATAW_ACK);
    bus_report(EV_DATAW_ACK);
    read_byte(15);
    read_byte(2);
    // Zero size on the read path, a load while busy, then a bus error.
    start_xfer(0);
    load_byte(5, 8'h3C);
    bus_report(EV_ADDRR_ACK);
    bus_report(EV_ERROR);
    // Oversized start, restart while busy, then a two-byte read.
    start_xfer(31);
    start_xfer(2);
    bus_report(EV_RSTART);
    bus_report(EV_ADDRR_ACK);
    bus_report(EV_RX_NACK);
    read_byte(1);
    read_byte(5);

    // Random transfers with some noise in between.
    while (offered < TARGET_WORDS) begin
      if (!hold_req && offered >= 200) hold_req <= 1'b1;
      if (!drained && offered >= 450) begin
        settle();
        drained = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: write_transfer();
        4, 5, 6, 7: read_transfer();
        default: begin
          repeat ($urandom_range(1, 6)) begin
            w = word_of(OP_LOAD);
            w.op = 2'($urandom_range(0, 3));
            offer(w);
          end
        end
      endcase
    end

    // Drain and give the verdict.
    in_valid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (pending != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("i2c_master_transfer_sequencer_top_tb: clean");
    end else begin
      $display("i2c_master_transfer_sequencer_top_tb: errors");
    end
    $finish;
  end

  // Hard limit on the run.
  initial begin
    #5ms;
    $display("i2c_master_transfer_sequencer_top_tb: errors");
    $finish;
  end

endmodule
